FILE: design/led_cube_bitplane_framebuffer_assert.svh
// Assertion macros for the LED cube bit-plane frame buffer.
`ifndef LED_CUBE_BITPLANE_FRAMEBUFFER_ASSERT_SVH
`define LED_CUBE_BITPLANE_FRAMEBUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define LCB_FB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define LCB_FB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lcb_fb_pkg.sv
// Types and constants shared by the LED cube bit-plane frame buffer.
`default_nettype none

package lcb_fb_pkg;

	typedef logic [1:0] op_t;
	typedef logic [2:0] coord_t;
	typedef logic [4:0] channel_t;
	typedef logic [3:0] sel_t;
	typedef logic [7:0] byte_t;

	localparam int unsigned CUBE_N      = 5;
	localparam int unsigned VOXELS      = CUBE_N * CUBE_N * CUBE_N;
	localparam int unsigned PLANE_BYTES = 10;
	localparam int unsigned ROW_W       = PLANE_BYTES * 8;
	localparam int unsigned VIDX_W      = 7;
	localparam int unsigned POS_W       = 7;

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		channel_t blue;
		channel_t green;
		channel_t red;
	} color_t;

	localparam op_t OP_SET   = 2'd0;
	localparam op_t OP_GET   = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;
	localparam op_t OP_READ  = 2'd3;

	localparam coord_t COORD_MAX   = 3'd4;
	localparam sel_t   BYTE_MAX    = 4'd9;
	localparam byte_t  LAYER_TOP   = 8'd4;
	localparam int unsigned RED_OFFSET = 5;
	localparam int unsigned X_STRIDE   = 3;
	localparam int unsigned Z_STRIDE   = 15;

	// Plane row after reset or clear: byte 0 holds the layer-select code 4-y.
	function automatic row_t layer_pattern(coord_t y);
		byte_t code;
		code = LAYER_TOP - {5'b0, y};
		return {{(ROW_W-8){1'b0}}, code};
	endfunction

	function automatic byte_t row_byte(row_t row, sel_t sel);
		byte_t b;
		case (sel)
			4'd0: b = row[7:0];
			4'd1: b = row[15:8];
			4'd2: b = row[23:16];
			4'd3: b = row[31:24];
			4'd4: b = row[39:32];
			4'd5: b = row[47:40];
			4'd6: b = row[55:48];
			4'd7: b = row[63:56];
			4'd8: b = row[71:64];
			4'd9: b = row[79:72];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: design/led_cube_bitplane_framebuffer.sv
// Top level of the LED cube bit-plane frame buffer.
`default_nettype none

// A command is taken at a rising edge where start is high and busy is low, and
// every command gives exactly one result, shown on the result ports for a
// single cycle with done high; the receiver cannot stall it, so it must sample
// the ports whenever done is high. Result and done are registered together
// in the lookup state. A get, a clear, a plane byte read, a set with a
// coordinate out of range and a set that leaves the colour unchanged keep busy
// high for the lookup state only. A set that changes the colour also keeps it
// high through the rewrite state, because it rewrites one row in each of the
// PLANES bit planes of the layer through a single read-modify-write port
// of the plane memory; its result (the old colour) comes from the lookup
// state, while the plane rewrite goes on. A clear takes effect at once through
// a bank of row valid bits, so there is no clearing pass after reset or clear.
module led_cube_bitplane_framebuffer #(
	parameter int unsigned PLANES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lcb_fb_pkg::op_t      operation,
	input  lcb_fb_pkg::coord_t   x_pos,
	input  lcb_fb_pkg::coord_t   y_layer,
	input  lcb_fb_pkg::coord_t   z_pos,
	input  lcb_fb_pkg::channel_t red,
	input  lcb_fb_pkg::channel_t green,
	input  lcb_fb_pkg::channel_t blue,
	input  lcb_fb_pkg::sel_t     plane_index,
	input  lcb_fb_pkg::sel_t     byte_index,
	output logic                 busy,
	output logic                 done,
	output lcb_fb_pkg::channel_t old_red,
	output lcb_fb_pkg::channel_t old_green,
	output lcb_fb_pkg::channel_t old_blue,
	output lcb_fb_pkg::byte_t    plane_byte
);
	import lcb_fb_pkg::*;

	`include "led_cube_bitplane_framebuffer_assert.svh"

	// One plane row holds all ten bytes of one plane of one layer.
	localparam int unsigned ROWS = CUBE_N * PLANES;
	localparam int unsigned RAW  = $clog2(ROWS);
	localparam int unsigned PW   = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam logic [PW-1:0] LAST_PLANE = PW'(PLANES - 1);
	localparam logic [6:0] PLANES_W = 7'(PLANES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_RMW  = 2'd2;

	// Channels above the plane count are clipped to it.
	function automatic channel_t sat_ch(channel_t c);
		return ({2'b00, c} > PLANES_W) ? PLANES_W[4:0] : c;
	endfunction

	logic [1:0]         state_q;
	logic               accept;

	// Item registers, loaded when a command is taken.
	op_t                op_q;
	coord_t             y_q;
	color_t             new_q;
	sel_t               byte_q;
	logic               coord_ok_q;
	logic               rd_ok_q;
	logic [VIDX_W-1:0]  vidx_q;
	logic [POS_W-1:0]   pos_q;
	logic [RAW-1:0]     ybase_q;

	// Voxel colour memory with its valid bits.
	color_t             vm [VOXELS];
	color_t             vm_rdata_q;
	logic               vm_rvalid_q;
	logic [VOXELS-1:0]  vvalid_q;
	logic               vm_we;
	logic [7:0]         vidx_w;
	color_t             old_color;

	// Plane memory with its row valid bits.
	row_t               pm [ROWS];
	row_t               pm_rdata_q;
	logic               pm_rvalid_q;
	logic [ROWS-1:0]    pvalid_q;
	logic [RAW-1:0]     pm_raddr;
	row_t               cur_row;

	// Plane rewrite sequencer: read issue, then write in the cycle after it.
	logic               rd_act_q;
	logic [PW-1:0]      rd_plane_q;
	logic               wr_v_s1;
	logic [PW-1:0]      wr_plane_s1;
	logic [RAW-1:0]     wr_row_s1;
	row_t               wr_data;
	logic [2:0]         wr_bits;

	logic               coord_ok_in;
	logic               rd_ok_in;
	logic [POS_W-1:0]   pos_in;

	logic               done_q;
	channel_t           old_red_q;
	channel_t           old_green_q;
	channel_t           old_blue_q;
	byte_t              plane_byte_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign coord_ok_in = (x_pos <= COORD_MAX) && (y_layer <= COORD_MAX) &&
		(z_pos <= COORD_MAX);
	assign rd_ok_in    = (y_layer <= COORD_MAX) && (32'(plane_index) < PLANES) &&
		(byte_index <= BYTE_MAX);

	// Voxel index is (x*5 + y)*5 + z; only meaningful when the coordinates fit.
	assign vidx_w = 8'(x_pos) * 8'd25 + 8'(y_layer) * 8'd5 + 8'(z_pos);
	assign pos_in = POS_W'(x_pos) * POS_W'(X_STRIDE) + POS_W'(z_pos) * POS_W'(Z_STRIDE) +
		POS_W'(RED_OFFSET);

	assign old_color = vm_rvalid_q ? vm_rdata_q : '0;
	assign vm_we     = (state_q == ST_LOOK) && (op_q == OP_SET) && coord_ok_q &&
		(new_q != old_color);

	// The single read port serves a plane byte read at acceptance and the
	// rewrite loop afterwards; the two never overlap.
	always_comb begin
		if (rd_act_q) begin
			pm_raddr = ybase_q + RAW'(rd_plane_q);
		end else begin
			pm_raddr = RAW'(32'(y_layer) * PLANES + 32'(plane_index));
		end
	end

	assign cur_row = pm_rvalid_q ? pm_rdata_q : layer_pattern(y_q);

	assign wr_row_s1 = ybase_q + RAW'(wr_plane_s1);

	// Thermometer code: plane i lights a channel when i is below its value.
	assign wr_bits = {7'(wr_plane_s1) < 7'(new_q.blue),
		7'(wr_plane_s1) < 7'(new_q.green),
		7'(wr_plane_s1) < 7'(new_q.red)};
	assign wr_data = (cur_row & ~(row_t'(3'b111) << pos_q)) | (row_t'(wr_bits) << pos_q);

	// Memories: registered reads, one write port each.
	always_ff @(posedge clk) begin
		if (accept) begin
			vm_rdata_q <= vm[vidx_w[VIDX_W-1:0]];
		end
		if (vm_we) begin
			vm[vidx_q] <= new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept || rd_act_q) begin
			pm_rdata_q <= pm[pm_raddr];
		end
		if (wr_v_s1) begin
			pm[wr_row_s1] <= wr_data;
		end
	end

	// Item registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= operation;
			y_q        <= y_layer;
			new_q      <= '{blue: sat_ch(blue), green: sat_ch(green), red: sat_ch(red)};
			byte_q     <= byte_index;
			coord_ok_q <= coord_ok_in;
			rd_ok_q    <= rd_ok_in;
			vidx_q     <= vidx_w[VIDX_W-1:0];
			pos_q      <= pos_in;
			ybase_q    <= RAW'(32'(y_layer) * PLANES);
		end
	end

	// Result registers; every field not produced by the command reads zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			case (op_q)
				OP_SET, OP_GET: begin
					old_red_q    <= coord_ok_q ? old_color.red : '0;
					old_green_q  <= coord_ok_q ? old_color.green : '0;
					old_blue_q   <= coord_ok_q ? old_color.blue : '0;
					plane_byte_q <= '0;
				end
				OP_READ: begin
					old_red_q    <= '0;
					old_green_q  <= '0;
					old_blue_q   <= '0;
					plane_byte_q <= rd_ok_q ? row_byte(cur_row, byte_q) : '0;
				end
				default: begin
					old_red_q    <= '0;
					old_green_q  <= '0;
					old_blue_q   <= '0;
					plane_byte_q <= '0;
				end
			endcase
		end
	end

	// Control: sequencer state, valid bits and the rewrite loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vvalid_q    <= '0;
			pvalid_q    <= '0;
			vm_rvalid_q <= 1'b0;
			pm_rvalid_q <= 1'b0;
			rd_act_q    <= 1'b0;
			rd_plane_q  <= '0;
			wr_v_s1     <= 1'b0;
			wr_plane_s1 <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == ST_LOOK);
			if (accept) begin
				vm_rvalid_q <= coord_ok_in && vvalid_q[vidx_w[VIDX_W-1:0]];
			end
			if (accept || rd_act_q) begin
				pm_rvalid_q <= pvalid_q[pm_raddr];
			end
			wr_v_s1     <= rd_act_q;
			wr_plane_s1 <= rd_plane_q;
			if (rd_act_q) begin
				if (rd_plane_q == LAST_PLANE) begin
					rd_act_q <= 1'b0;
				end
				rd_plane_q <= rd_plane_q + 1'b1;
			end
			if (wr_v_s1) begin
				pvalid_q[wr_row_s1] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (op_q == OP_CLEAR) begin
						pvalid_q <= '0;
					end
					if (vm_we) begin
						vvalid_q[vidx_q] <= 1'b1;
						state_q          <= ST_RMW;
						rd_act_q         <= 1'b1;
						rd_plane_q       <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RMW: begin
					if (wr_v_s1 && (wr_plane_s1 == LAST_PLANE)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign old_red    = old_red_q;
	assign old_green  = old_green_q;
	assign old_blue   = old_blue_q;
	assign plane_byte = plane_byte_q;

	// A result lasts exactly one cycle, since a lookup never repeats back to back.
	`LCB_FB_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")
	// A taken command always makes the block busy in the next cycle.
	`LCB_FB_ASSERT_NXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
	// The rewrite loop never reads the row it is writing in the same cycle.
	`LCB_FB_ASSERT_IMP(a_rmw_no_clash, rd_act_q && wr_v_s1, pm_raddr != wr_row_s1,
		"plane read and write hit the same row")

endmodule

`default_nettype wire

FILE: bench/tb_led_cube_bitplane_framebuffer.sv
// Self-checking testbench for the LED cube bit-plane frame buffer.
module tb_led_cube_bitplane_framebuffer;

	import lcb_fb_pkg::*;

	// The block is built with its default plane count; the shadow copy of the
	// plane memory below is sized to match.
	localparam int unsigned PLANES     = 16;
	localparam int unsigned ITEMS      = 600;
	localparam int unsigned CYCLE_CAP  = 200000;
	localparam int unsigned DRAIN_CAP  = 64;

	// One command item as it goes into the block, and one result item as the
	// block shows it for a single cycle under done.
	typedef struct packed {
		op_t      op;
		coord_t   x;
		coord_t   y;
		coord_t   z;
		channel_t red;
		channel_t green;
		channel_t blue;
		sel_t     plane;
		sel_t     sel;
	} fb_cmd_t;

	typedef struct packed {
		channel_t red;
		channel_t green;
		channel_t blue;
		byte_t    plane_byte;
	} fb_resp_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	op_t      operation = OP_GET;
	coord_t   x_pos = '0;
	coord_t   y_layer = '0;
	coord_t   z_pos = '0;
	channel_t red = '0;
	channel_t green = '0;
	channel_t blue = '0;
	sel_t     plane_index = '0;
	sel_t     byte_index = '0;
	logic     busy;
	logic     done;
	channel_t old_red;
	channel_t old_green;
	channel_t old_blue;
	byte_t    plane_byte;

	// Shadow of the frame buffer: the stored colour of every voxel and every
	// byte of every bit plane, kept in step with the items the block accepts.
	color_t voxel_shadow [VOXELS];
	byte_t  plane_shadow [CUBE_N][PLANES][PLANE_BYTES];

	fb_cmd_t  command_queue[$];
	fb_resp_t expected_readback[$];
	fb_cmd_t  staged;

	int unsigned total_cmds;
	int unsigned issued;
	int unsigned n_results;
	int unsigned n_errors;
	int unsigned n_redraw;
	int unsigned n_unchanged;
	int unsigned n_get;
	int unsigned n_clear;
	int unsigned n_read;
	int unsigned n_outside;
	int unsigned cycle_count;

	led_cube_bitplane_framebuffer #(.PLANES(PLANES)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		n_errors++;
		$display("[%0d] mismatch: %s", cycle_count, what);
	endtask

	// Every plane goes back to all zero, except byte 0, which carries the
	// layer-select code 4-y for its layer.
	function automatic void restore_planes();
		for (int y = 0; y < CUBE_N; y++) begin
			for (int i = 0; i < PLANES; i++) begin
				for (int b = 0; b < PLANE_BYTES; b++) begin
					plane_shadow[y][i][b] = (b == 0) ? byte_t'(4 - y) : 8'd0;
				end
			end
		end
	endfunction

	function automatic channel_t saturate(input channel_t v);
		return (v > PLANES) ? channel_t'(PLANES) : v;
	endfunction

	// Works out the result of one accepted command and updates the shadow
	// state exactly as the frame buffer should.
	function automatic void framebuffer_step(input fb_cmd_t c, output fb_resp_t r);
		int unsigned vidx;
		int unsigned pos;
		int unsigned p;
		int unsigned level [3];
		color_t prev;
		color_t fresh;
		r = '0;
		case (c.op)
			OP_SET, OP_GET: begin
				if (c.x > COORD_MAX || c.y > COORD_MAX || c.z > COORD_MAX) begin
					n_outside++;
				end else begin
					vidx = (c.x * CUBE_N + c.y) * CUBE_N + c.z;
					prev = voxel_shadow[vidx];
					r.red = prev.red;
					r.green = prev.green;
					r.blue = prev.blue;
					if (c.op == OP_GET) begin
						n_get++;
					end else begin
						fresh.red = saturate(c.red);
						fresh.green = saturate(c.green);
						fresh.blue = saturate(c.blue);
						if (fresh == prev) begin
							n_unchanged++;
						end else begin
							n_redraw++;
							voxel_shadow[vidx] = fresh;
							level[0] = fresh.red;
							level[1] = fresh.green;
							level[2] = fresh.blue;
							pos = c.x * X_STRIDE + c.z * Z_STRIDE + RED_OFFSET;
							// Thermometer code: plane i lights a channel while
							// i is below that channel's level.
							for (int i = 0; i < PLANES; i++) begin
								for (int ch = 0; ch < 3; ch++) begin
									p = pos + ch;
									plane_shadow[c.y][i][p >> 3][p & 7] = (i < level[ch]);
								end
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				n_clear++;
				restore_planes();
			end
			default: begin
				n_read++;
				if (c.y <= COORD_MAX && c.plane < PLANES && c.sel <= BYTE_MAX)
					r.plane_byte = plane_shadow[c.y][c.plane][c.sel];
			end
		endcase
	endfunction

	function automatic fb_cmd_t make_cmd(input op_t op, input int unsigned x, y, z,
			input int unsigned rd, gr, bl, input int unsigned pl, sl);
		fb_cmd_t c;
		c.op = op;
		c.x = coord_t'(x);
		c.y = coord_t'(y);
		c.z = coord_t'(z);
		c.red = channel_t'(rd);
		c.green = channel_t'(gr);
		c.blue = channel_t'(bl);
		c.plane = sel_t'(pl);
		c.sel = sel_t'(sl);
		return c;
	endfunction

	function automatic int unsigned random_level();
		// Mostly legal levels, now and then one that must saturate.
		return ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(16);
	endfunction

	// Driver. An item is taken at an edge where start is high and busy low; at
	// that edge its result is predicted. A fresh item is put up only when no item
	// is still waiting, and start is assigned once per edge so that a start that
	// stays high for back-to-back items is never lowered and raised again.
	always @(posedge clk) begin : drive_commands
		fb_cmd_t  nxt;
		fb_resp_t resp;
		logic     take;
		logic     start_nxt;
		logic     hold_off;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			take = start && !busy;
			start_nxt = start && !take;
			if (take) begin
				framebuffer_step(staged, resp);
				expected_readback.push_back(resp);
				issued++;
			end
			// The sender idles about one cycle in five, except for a long calm
			// stretch in the middle of the random part.
			hold_off = !(issued >= 260 && issued < 400) && ($urandom_range(99) < 19);
			if (!start_nxt && command_queue.size() != 0 && !hold_off) begin
				nxt = command_queue.pop_front();
				staged <= nxt;
				operation <= nxt.op;
				x_pos <= nxt.x;
				y_layer <= nxt.y;
				z_pos <= nxt.z;
				red <= nxt.red;
				green <= nxt.green;
				blue <= nxt.blue;
				plane_index <= nxt.plane;
				byte_index <= nxt.sel;
				start_nxt = 1'b1;
			end
			start <= start_nxt;
		end
	end

	// Monitor. Results cannot be held off, so every cycle with done high is
	// one result item, checked field by field against the oldest prediction.
	always @(posedge clk) begin : check_readback
		fb_resp_t want;
		if (arst_n && done) begin
			n_results++;
			if (expected_readback.size() == 0) begin
				report_mismatch("result strobe with no command outstanding");
			end else begin
				want = expected_readback.pop_front();
				if (old_red !== want.red)
					report_mismatch($sformatf("result %0d old_red %0d, expected %0d",
						n_results, old_red, want.red));
				if (old_green !== want.green)
					report_mismatch($sformatf("result %0d old_green %0d, expected %0d",
						n_results, old_green, want.green));
				if (old_blue !== want.blue)
					report_mismatch($sformatf("result %0d old_blue %0d, expected %0d",
						n_results, old_blue, want.blue));
				if (plane_byte !== want.plane_byte)
					report_mismatch($sformatf("result %0d plane_byte %02h, expected %02h",
						n_results, plane_byte, want.plane_byte));
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL led_cube_bitplane_framebuffer");
		$finish;
	end

	initial begin : run_sequence
		int unsigned pick;
		int unsigned roll;
		int unsigned k;
		int unsigned x, y, z, rd, gr, bl, pl, sl;
		fb_cmd_t c;

		for (int v = 0; v < VOXELS; v++)
			voxel_shadow[v] = '0;
		restore_planes();

		// Directed part: reset pattern, saturation, the far corner, unchanged
		// colours, coordinates and read addresses out of range, and a clear
		// that leaves the stored colours behind.
		command_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 4, 0, 0, 0, 0, 15, 0));
		command_queue.push_back(make_cmd(OP_SET, 0, 0, 0, 31, 16, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 15, 0));
		command_queue.push_back(make_cmd(OP_SET, 4, 4, 4, 16, 16, 16, 15, 15));
		command_queue.push_back(make_cmd(OP_READ, 0, 4, 0, 0, 0, 0, 15, 9));
		command_queue.push_back(make_cmd(OP_SET, 4, 4, 4, 16, 16, 16, 0, 0));
		command_queue.push_back(make_cmd(OP_SET, 4, 4, 4, 17, 31, 20, 0, 0));
		command_queue.push_back(make_cmd(OP_SET, 2, 3, 1, 1, 8, 15, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 3, 0, 0, 0, 0, 0, 3));
		command_queue.push_back(make_cmd(OP_READ, 0, 3, 0, 0, 0, 0, 8, 3));
		command_queue.push_back(make_cmd(OP_SET, 7, 0, 0, 9, 9, 9, 0, 0));
		command_queue.push_back(make_cmd(OP_SET, 0, 5, 0, 9, 9, 9, 0, 0));
		command_queue.push_back(make_cmd(OP_GET, 0, 0, 6, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 5, 0, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 2, 0, 0, 0, 0, 0, 10));
		command_queue.push_back(make_cmd(OP_READ, 0, 2, 0, 0, 0, 0, 15, 15));
		command_queue.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 4, 0, 0, 0, 0, 15, 9));
		command_queue.push_back(make_cmd(OP_GET, 4, 4, 4, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_SET, 4, 4, 4, 16, 16, 16, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 4, 0, 0, 0, 0, 0, 9));
		command_queue.push_back(make_cmd(OP_SET, 4, 4, 4, 0, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(OP_READ, 0, 4, 0, 0, 0, 0, 0, 0));

		// Random part. Sets on legal voxels are the largest share, often followed by
		// a repeat of the same colour or by a read of the byte that holds the
		// voxel's red bit; gets, plane reads, the odd clear and a little noise
		// with every field free make up the rest.
		while (command_queue.size() < ITEMS) begin
			pick = $urandom_range(99);
			x = $urandom_range(4);
			y = $urandom_range(4);
			z = $urandom_range(4);
			rd = random_level();
			gr = random_level();
			bl = random_level();
			pl = $urandom_range(15);
			sl = $urandom_range(15);
			if (pick < 38) begin
				c = make_cmd(OP_SET, x, y, z, rd, gr, bl, pl, sl);
				command_queue.push_back(c);
				roll = $urandom_range(3);
				if (roll == 0)
					command_queue.push_back(c);
				else if (roll == 1)
					command_queue.push_back(make_cmd(OP_READ, x, y, z, rd, gr, bl, pl,
						(x * X_STRIDE + z * Z_STRIDE + RED_OFFSET) >> 3));
			end else if (pick < 53) begin
				command_queue.push_back(make_cmd(OP_GET, x, y, z, rd, gr, bl, pl, sl));
			end else if (pick < 83) begin
				command_queue.push_back(make_cmd(OP_READ, x, y, z, rd, gr, bl, pl,
					$urandom_range(9)));
			end else if (pick < 85) begin
				command_queue.push_back(make_cmd(OP_CLEAR, x, y, z, rd, gr, bl, pl, sl));
			end else begin
				command_queue.push_back(make_cmd(op_t'($urandom_range(3)),
					$urandom_range(7), $urandom_range(7), $urandom_range(7),
					$urandom_range(31), $urandom_range(31), $urandom_range(31),
					pl, sl));
			end
		end
		total_cmds = command_queue.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Every command taken, then every result back, then a tail long enough
		// for a plane rewrite to finish so that a stray strobe would be seen.
		while (issued < total_cmds)
			@(posedge clk);
		for (k = 0; k < DRAIN_CAP && expected_readback.size() != 0; k++)
			@(posedge clk);
		repeat (PLANES + 8) @(posedge clk);
		if (expected_readback.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				expected_readback.size()));

		$display("covered %0d commands: %0d redrawing sets, %0d unchanged sets, %0d gets,",
			total_cmds, n_redraw, n_unchanged, n_get);
		$display("  %0d plane byte reads, %0d clears, %0d out of range; %0d results checked",
			n_read, n_clear, n_outside, n_results);
		if (n_errors == 0) begin
			$display("PASS led_cube_bitplane_framebuffer");
		end else begin
			$display("FAIL led_cube_bitplane_framebuffer");
		end
		$finish;
	end

endmodule
